[rtl/core/i2cdac_pkg.sv]
// ----------------------------------------------------------------------------
// i2cdac_pkg
// Shared constants for the I2C DAC fast-write master: field widths, command
// and register index codes, and the millivolt-to-code reciprocal constants.
// ----------------------------------------------------------------------------
package i2cdac_pkg;

  // Width of the DAC code carried in the frame
  localparam int unsigned CODE_BITS = 12;
  localparam longint unsigned MAX_CODE = (64'd1 << CODE_BITS) - 64'd1;

  // Input field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CODEIN_W = 12;
  localparam int unsigned MV_W   = 12;

  // Stream data widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_VOLT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

  // Register reset values
  localparam logic [6:0]  RST_ADDR_CODE = 7'd96;
  localparam logic [6:0]  RST_ADDR_VOLT = 7'd97;
  localparam logic [7:0]  RST_HALF_PER  = 8'd2;
  localparam logic [7:0]  RST_ACK_TMO   = 8'd250;
  localparam logic [15:0] RST_GAP       = 16'd10000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CODE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MVOLT = 2'd2;

  // Millivolt scaling: code = floor(2^CODE_BITS * mv / MV_FULL_SCALE),
  // done as mv * ceil(2^(MV_SHIFT+CODE_BITS) / MV_FULL_SCALE) >> MV_SHIFT,
  // which is exact for every 12-bit mv since 2^MV_SHIFT > 4096 * 3300.
  localparam longint unsigned MV_FULL_SCALE = 64'd3300;
  localparam int unsigned     MV_SHIFT      = 24;
  localparam longint unsigned MV_MULT =
    ((64'd1 << (MV_SHIFT + CODE_BITS)) + MV_FULL_SCALE - 64'd1) / MV_FULL_SCALE;
  localparam int unsigned MV_MULT_W = $clog2(MV_MULT + 64'd1);
  localparam int unsigned MV_PROD_W = MV_W + MV_MULT_W;
  localparam int unsigned MV_QUOT_W = MV_PROD_W - MV_SHIFT;

endpackage

[rtl/core/i2cdac_mv2code.sv]
// ----------------------------------------------------------------------------
// i2cdac_mv2code
// Converts a millivolt target to a DAC code by a constant reciprocal
// multiply, saturating at the largest code.
// ----------------------------------------------------------------------------
module i2cdac_mv2code (
  input  logic [i2cdac_pkg::MV_W-1:0]      mv,
  output logic [i2cdac_pkg::CODE_BITS-1:0] code
);
  import i2cdac_pkg::*;

  logic [MV_PROD_W-1:0] prod;
  logic [MV_QUOT_W-1:0] quot;

  // Scale by the reciprocal of full scale, keep the integer part
  assign prod = MV_PROD_W'(mv) * MV_PROD_W'(MV_MULT);
  assign quot = prod[MV_PROD_W-1:MV_SHIFT];

  // Clamp to the largest code
  assign code = (quot > MV_QUOT_W'(MAX_CODE)) ? CODE_BITS'(MAX_CODE)
                                               : CODE_BITS'(quot);

endmodule

[rtl/core/i2c_dac_fast_write_master.sv]
// Path: an input transaction is held in the input register, then the tick step
//   writes its result into the result register.
// Throughput: one tick per cycle unless a stalled result holds the flow; the
//   input register refills in the same cycle the result register takes its result.
// Reset (rst_n low, synchronous): bus sequencer idle, all counters and the
//   error flag cleared, registers back to their default values.
// ----------------------------------------------------------------------------
// i2c_dac_fast_write_master
// Tick-level I2C master that sends a start, an address byte and two DAC code
// bytes with ACK polls, then a stop and a settle gap.
// ----------------------------------------------------------------------------
module i2c_dac_fast_write_master (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [11:0] code, [23:12] millivolts, [24] sda_in, [31:25] zero
  input  logic [i2cdac_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [i2cdac_pkg::CMD_W-1:0]       in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
  // [4] frame_done, [5] ack_error, [7:6] zero
  output logic [i2cdac_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [i2cdac_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [i2cdac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cdac_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_HI = 4'd1,
    PH_START_LO = 4'd2,
    PH_BIT_LO   = 4'd3,
    PH_BIT_HI   = 4'd4,
    PH_ACK_LO   = 4'd5,
    PH_ACK_HI   = 4'd6,
    PH_STOP_LO  = 4'd7,
    PH_STOP_HI  = 4'd8,
    PH_GAP      = 4'd9
  } phase_t;

  // Configuration registers
  logic [6:0]  addr_code_r, addr_volt_r;
  logic [7:0]  half_per_r, ack_tmo_r;
  logic [15:0] gap_r;

  // Input register
  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  logic [CODEIN_W-1:0]  s1_code_r;
  logic [MV_W-1:0]      s1_mv_r;
  logic                 s1_sda_r;

  // Sequencer state
  phase_t      phase_r, phase_nxt, phase_cur;
  logic [7:0]  shift_r, shift_nxt, shift_cur;
  logic [2:0]  bit_idx_r, bit_idx_nxt, bit_idx_cur;
  logic [1:0]  byte_idx_r, byte_idx_nxt, byte_idx_cur;
  logic [23:0] frame_r, frame_nxt, frame_cur;
  logic [15:0] tick_r, tick_nxt, tick_cur;
  logic        err_r, err_nxt, err_cur;

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Step helpers
  logic                 advance;
  logic [CODE_BITS-1:0] mv_code, new_code;
  logic [15:0]          code_word;
  logic [6:0]           new_addr;
  logic [7:0]           half_eff;
  logic [15:0]          half_tick, ack_tick;
  logic                 half_hit;
  logic [2:0]           bit_inc;
  logic [1:0]           byte_inc;
  logic                 scl_o, sda_o, drv_o, busy_o, done_o;

  // Millivolt conversion
  i2cdac_mv2code u_mv2code (
    .mv   (s1_mv_r),
    .code (mv_code)
  );

  // Handshake: step the input register whenever the result slot frees
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_code_r <= RST_ADDR_CODE;
      addr_volt_r <= RST_ADDR_VOLT;
      half_per_r  <= RST_HALF_PER;
      ack_tmo_r   <= RST_ACK_TMO;
      gap_r       <= RST_GAP;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ADDR_CODE: addr_code_r <= cfg_wdata[6:0];
        CFG_ADDR_VOLT: addr_volt_r <= cfg_wdata[6:0];
        CFG_HALF_PER:  half_per_r  <= cfg_wdata[7:0];
        CFG_ACK_TMO:   ack_tmo_r   <= cfg_wdata[7:0];
        CFG_GAP:       gap_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_code_r <= in_tdata[11:0];
      s1_mv_r   <= in_tdata[23:12];
      s1_sda_r  <= in_tdata[24];
    end
  end

  // Frame code for the pending command
  assign new_code  = (s1_cmd_r == CMD_CODE) ? CODE_BITS'(s1_code_r) : mv_code;
  assign new_addr  = (s1_cmd_r == CMD_CODE) ? addr_code_r : addr_volt_r;
  assign code_word = 16'(new_code);
  assign half_eff  = (half_per_r == 8'd0) ? 8'd1 : half_per_r;

  // One tick of the bus sequencer
  always_comb begin
    phase_cur    = phase_r;
    shift_cur    = shift_r;
    bit_idx_cur  = bit_idx_r;
    byte_idx_cur = byte_idx_r;
    frame_cur    = frame_r;
    tick_cur     = tick_r;
    err_cur      = err_r;
    done_o       = 1'b0;

    // End the settle gap
    if (phase_r == PH_GAP && tick_r >= gap_r) begin
      done_o    = 1'b1;
      phase_cur = PH_IDLE;
      tick_cur  = 16'd0;
    end

    // Start a frame on a write command while idle
    if (phase_cur == PH_IDLE && (s1_cmd_r == CMD_CODE || s1_cmd_r == CMD_MVOLT)) begin
      frame_cur    = {new_addr, 1'b0, code_word[15:8], code_word[7:0]};
      err_cur      = 1'b0;
      byte_idx_cur = 2'd0;
      bit_idx_cur  = 3'd0;
      shift_cur    = frame_cur[23:16];
      tick_cur     = 16'd0;
      phase_cur    = PH_START_HI;
    end

    busy_o    = (phase_cur != PH_IDLE);
    half_tick = tick_cur + 16'd1;
    half_hit  = (half_tick >= 16'(half_eff));
    ack_tick  = tick_cur + 16'd1;
    bit_inc   = bit_idx_cur + 3'd1;
    byte_inc  = byte_idx_cur + 2'd1;

    phase_nxt    = phase_cur;
    shift_nxt    = shift_cur;
    bit_idx_nxt  = bit_idx_cur;
    byte_idx_nxt = byte_idx_cur;
    frame_nxt    = frame_cur;
    tick_nxt     = tick_cur;
    err_nxt      = err_cur;
    scl_o        = 1'b1;
    sda_o        = 1'b1;
    drv_o        = 1'b1;

    case (phase_cur)
      PH_IDLE: ;
      PH_START_HI: begin
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_START_LO;
      end
      PH_START_LO: begin
        sda_o    = 1'b0;
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_BIT_LO;
      end
      PH_BIT_LO: begin
        scl_o    = 1'b0;
        sda_o    = shift_cur[7];
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        sda_o    = shift_cur[7];
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) begin
          shift_nxt   = {shift_cur[6:0], 1'b0};
          bit_idx_nxt = bit_inc;
          phase_nxt   = (bit_inc == 3'd0) ? PH_ACK_LO : PH_BIT_LO;
        end
      end
      PH_ACK_LO: begin
        scl_o    = 1'b0;
        drv_o    = 1'b0;
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        drv_o = 1'b0;
        if (!s1_sda_r) begin
          // ACK seen: next byte or stop after the last one
          tick_nxt     = 16'd0;
          byte_idx_nxt = byte_inc;
          if (byte_inc == 2'd0 || byte_inc == 2'd3) begin
            phase_nxt = PH_STOP_LO;
          end else begin
            shift_nxt   = (byte_inc == 2'd1) ? frame_cur[15:8] : frame_cur[7:0];
            bit_idx_nxt = 3'd0;
            phase_nxt   = PH_BIT_LO;
          end
        end else if (ack_tick > 16'(ack_tmo_r)) begin
          // Timeout: flag and stop
          err_nxt   = 1'b1;
          tick_nxt  = 16'd0;
          phase_nxt = PH_STOP_LO;
        end else begin
          tick_nxt = ack_tick;
        end
      end
      PH_STOP_LO: begin
        scl_o    = 1'b0;
        sda_o    = 1'b0;
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        sda_o    = 1'b0;
        tick_nxt = half_hit ? 16'd0 : half_tick;
        if (half_hit) phase_nxt = PH_GAP;
      end
      PH_GAP: begin
        tick_nxt = tick_cur + 16'd1;
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 16'd0;
        busy_o    = 1'b0;
      end
    endcase

    // Released SDA reads high
    if (!drv_o) sda_o = 1'b1;
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= 8'd0;
      bit_idx_r   <= 3'd0;
      byte_idx_r  <= 2'd0;
      frame_r     <= 24'd0;
      tick_r      <= 16'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bit_idx_r   <= bit_idx_nxt;
      byte_idx_r  <= byte_idx_nxt;
      frame_r     <= frame_nxt;
      tick_r      <= tick_nxt;
      err_r       <= err_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, err_nxt, done_o, busy_o, drv_o, sda_o, scl_o};
    end
  end

endmodule

[rtl/core/i2cdac_chk.sv]
// ----------------------------------------------------------------------------
// i2cdac_chk
// Port-level checks for the I2C DAC fast-write master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cdac_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Idle ticks keep both lines high and driven
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[0] && out_tdata[1] && out_tdata[2])
    else $error("bus lines not released while idle");

  // Gap end pulse never comes with the SCL low
  a_done_scl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[0] && out_tdata[2])
    else $error("frame done with SCL low or SDA released");

endmodule

bind i2c_dac_fast_write_master i2cdac_chk u_i2cdac_chk (.*);

[sim/i2c_dac_fast_write_master_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_dac_fast_write_master_tb
// Self-checking bench for the tick-level I2C DAC fast-write master. A queue
// of ticks feeds a bursty stream driver, a cycle-level model of the bus
// sequencer predicts the pin levels and status of every accepted tick, and
// a monitor compares each result transaction against the oldest prediction
// while the result side stalls on its own pattern. Registers are changed
// only with the bus sequencer back in idle and the stream drained.
// ----------------------------------------------------------------------------
module i2c_dac_fast_write_master_tb;
  import i2cdac_pkg::*;

  // Spare command code, behaves as a plain tick
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  // Quiet cycles tolerated by the watchdog
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 200;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START_HIGH, SEQ_START_LOW, SEQ_BIT_LOW, SEQ_BIT_HIGH,
    SEQ_ACK_LOW, SEQ_ACK_POLL, SEQ_STOP_LOW, SEQ_STOP_HIGH, SEQ_SETTLE
  } seq_phase_t;

  // One tick of stimulus
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CODEIN_W-1:0] code;
    logic [MV_W-1:0]     mv;
    logic                sda;
  } tick_t;

  // Result fields, scl_level in bit 0 as on out_tdata
  typedef struct packed {
    logic ack_error;
    logic frame_done;
    logic busy;
    logic sda_drive;
    logic sda_level;
    logic scl_level;
  } pins_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [CMD_W-1:0]       in_tuser  = CMD_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr  = CFG_ADDR_CODE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  tick_t tick_queue[$];
  pins_t expected_pins[$];

  int ticks_queued    = 0;
  int ticks_accepted  = 0;
  int results_checked = 0;
  int frames_started  = 0;
  int nack_frames     = 0;
  int settle_ends     = 0;
  int reg_writes      = 0;
  int mismatches      = 0;

  // Sequencer model state and its copy of the registers
  seq_phase_t  seq_phase;
  logic [7:0]  tx_shift;
  logic [2:0]  bit_cnt;
  logic [1:0]  byte_cnt;
  logic [23:0] frame_word;
  logic [15:0] phase_ticks;
  logic        nack_seen;
  logic [6:0]  addr_direct;
  logic [6:0]  addr_mvolt;
  logic [7:0]  half_ticks;
  logic [7:0]  poll_limit;
  logic [15:0] settle_ticks;

  i2c_dac_fast_write_master u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Advance the phase tick counter; true once a half SCL period is over
  function automatic logic half_phase_over();
    logic [7:0] h;
    h = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
    phase_ticks = phase_ticks + 16'd1;
    if (phase_ticks >= {8'd0, h}) begin
      phase_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the sequencer model by one tick and return its pin levels
  function automatic pins_t step_sequencer(input logic [CMD_W-1:0] cmd,
                                           input logic [CODEIN_W-1:0] code_in,
                                           input logic [MV_W-1:0] mv,
                                           input logic sda_in);
    pins_t            p;
    longint unsigned  scaled;
    logic [11:0]      dac_code;
    logic [6:0]       addr;
    p = '0;
    p.scl_level = 1'b1;
    p.sda_level = 1'b1;
    p.sda_drive = 1'b1;

    // Close the settle gap; a command on this very tick still starts a frame
    if (seq_phase == SEQ_SETTLE && phase_ticks >= settle_ticks) begin
      p.frame_done = 1'b1;
      seq_phase = SEQ_IDLE;
      phase_ticks = '0;
      settle_ends++;
    end

    // Load a new frame: address byte, upper code bits, lower code bits
    if (seq_phase == SEQ_IDLE && (cmd == CMD_CODE || cmd == CMD_MVOLT)) begin
      if (cmd == CMD_CODE) begin
        dac_code = code_in;
        addr = addr_direct;
      end else begin
        scaled = mv;
        scaled = (scaled << CODE_BITS) / MV_FULL_SCALE;
        dac_code = (scaled > MAX_CODE) ? 12'(MAX_CODE) : scaled[11:0];
        addr = addr_mvolt;
      end
      frame_word = {addr, 1'b0, 4'd0, dac_code};
      nack_seen = 1'b0;
      byte_cnt = '0;
      bit_cnt = '0;
      tx_shift = frame_word[23:16];
      phase_ticks = '0;
      seq_phase = SEQ_START_HIGH;
      frames_started++;
    end
    p.busy = (seq_phase != SEQ_IDLE);

    case (seq_phase)
      SEQ_IDLE: begin
      end
      SEQ_START_HIGH: begin
        if (half_phase_over()) seq_phase = SEQ_START_LOW;
      end
      SEQ_START_LOW: begin
        p.sda_level = 1'b0;
        if (half_phase_over()) seq_phase = SEQ_BIT_LOW;
      end
      SEQ_BIT_LOW: begin
        p.scl_level = 1'b0;
        p.sda_level = tx_shift[7];
        if (half_phase_over()) seq_phase = SEQ_BIT_HIGH;
      end
      SEQ_BIT_HIGH: begin
        p.sda_level = tx_shift[7];
        if (half_phase_over()) begin
          tx_shift = tx_shift << 1;
          bit_cnt = bit_cnt + 3'd1;
          seq_phase = (bit_cnt == 3'd0) ? SEQ_ACK_LOW : SEQ_BIT_LOW;
        end
      end
      SEQ_ACK_LOW: begin
        p.scl_level = 1'b0;
        p.sda_drive = 1'b0;
        if (half_phase_over()) seq_phase = SEQ_ACK_POLL;
      end
      SEQ_ACK_POLL: begin
        p.sda_drive = 1'b0;
        if (!sda_in) begin
          // ACK taken: next byte, or stop after the last one
          phase_ticks = '0;
          byte_cnt = byte_cnt + 2'd1;
          if (byte_cnt == 2'd3 || byte_cnt == 2'd0) begin
            seq_phase = SEQ_STOP_LOW;
          end else begin
            tx_shift = (byte_cnt == 2'd1) ? frame_word[15:8] : frame_word[7:0];
            bit_cnt = '0;
            seq_phase = SEQ_BIT_LOW;
          end
        end else begin
          // Count high samples; past the limit flag the frame and stop
          phase_ticks = phase_ticks + 16'd1;
          if (phase_ticks > {8'd0, poll_limit}) begin
            nack_seen = 1'b1;
            phase_ticks = '0;
            seq_phase = SEQ_STOP_LOW;
            nack_frames++;
          end
        end
      end
      SEQ_STOP_LOW: begin
        p.scl_level = 1'b0;
        p.sda_level = 1'b0;
        if (half_phase_over()) seq_phase = SEQ_STOP_HIGH;
      end
      SEQ_STOP_HIGH: begin
        p.sda_level = 1'b0;
        if (half_phase_over()) seq_phase = SEQ_SETTLE;
      end
      SEQ_SETTLE: begin
        phase_ticks = phase_ticks + 16'd1;
      end
      default: begin
        seq_phase = SEQ_IDLE;
        phase_ticks = '0;
        p.busy = 1'b0;
      end
    endcase

    if (!p.sda_drive) p.sda_level = 1'b1;
    p.ack_error = nack_seen;
    return p;
  endfunction

  // Monitor: register writes, result checks, then predictions for new ticks
  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (!rst_n) begin
      seq_phase    = SEQ_IDLE;
      tx_shift     = '0;
      bit_cnt      = '0;
      byte_cnt     = '0;
      frame_word   = '0;
      phase_ticks  = '0;
      nack_seen    = 1'b0;
      addr_direct  = RST_ADDR_CODE;
      addr_mvolt   = RST_ADDR_VOLT;
      half_ticks   = RST_HALF_PER;
      poll_limit   = RST_ACK_TMO;
      settle_ticks = RST_GAP;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ADDR_CODE: addr_direct  = cfg_wdata[6:0];
          CFG_ADDR_VOLT: addr_mvolt   = cfg_wdata[6:0];
          CFG_HALF_PER:  half_ticks   = cfg_wdata[7:0];
          CFG_ACK_TMO:   poll_limit   = cfg_wdata[7:0];
          CFG_GAP:       settle_ticks = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = pins_t'(out_tdata[5:0]);
        if (expected_pins.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending",
                                    results_checked));
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "result %0d got/want scl %b/%b sda %b/%b drv %b/%b busy %b/%b done %b/%b err %b/%b",
              results_checked, got.scl_level, want.scl_level, got.sda_level,
              want.sda_level, got.sda_drive, want.sda_drive, got.busy, want.busy,
              got.frame_done, want.frame_done, got.ack_error, want.ack_error));
          end
        end
        results_checked++;
      end
      if (in_tvalid && in_tready) begin
        expected_pins.push_back(step_sequencer(in_tuser, in_tdata[11:0],
                                               in_tdata[23:12], in_tdata[24]));
        ticks_accepted++;
      end
    end
  end

  // Driver: bursts of random length separated by short random gaps
  int    burst_left = 0;
  int    gap_left   = 0;
  tick_t next_tick;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (tick_queue.size() != 0) begin
        next_tick = tick_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_tick.cmd;
        in_tdata  <= {7'd0, next_tick.sda, next_tick.mv, next_tick.code};
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
          gap_left   <= $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure: new stall pattern whenever ready_cycle[7:0] is all ones
  logic [15:0] ready_cycle = '0;
  int          stall_mode  = 0;
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 16'd1;
    if (ready_cycle[7:0] == 8'hFF) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= (ready_cycle[1:0] != 2'd3);
      2:       out_tready <= ($urandom_range(0, 99) >= 30);
      default: out_tready <= ready_cycle[5] | 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog on stretches with no transaction on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("i2c_dac_fast_write_master_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_tick(input logic [CMD_W-1:0] cmd, input logic [11:0] code,
                            input logic [11:0] mv, input logic sda);
    tick_t t;
    t.cmd  = cmd;
    t.code = code;
    t.mv   = mv;
    t.sda  = sda;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // Queue one random tick; cmd_pct sets how often a frame is requested
  task automatic queue_random(input int cmd_pct, input int sda_pct);
    logic [CMD_W-1:0] cmd;
    logic [11:0]      mv;
    if ($urandom_range(0, 99) < cmd_pct) begin
      cmd = ($urandom_range(0, 1) != 0) ? CMD_CODE : CMD_MVOLT;
    end else begin
      cmd = ($urandom_range(0, 15) == 0) ? CMD_SPARE : CMD_TICK;
    end
    mv = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                     : 12'($urandom_range(0, 3300));
    queue_tick(cmd, 12'($urandom_range(0, 4095)), mv,
               ($urandom_range(0, 99) < sda_pct));
  endtask

  // Hold until every queued tick is accepted and every result checked
  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || expected_pins.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Tick the sequencer until the frame and its settle gap are over
  task automatic settle_bus(input int sda_pct);
    wait_drained();
    while (seq_phase != SEQ_IDLE) begin
      repeat (16) queue_random(0, sda_pct);
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_all(input int a_code, input int a_volt, input int half,
                           input int tmo, input int gap);
    write_reg(CFG_ADDR_CODE, 16'(a_code));
    write_reg(CFG_ADDR_VOLT, 16'(a_volt));
    write_reg(CFG_HALF_PER, 16'(half));
    write_reg(CFG_ACK_TMO, 16'(tmo));
    write_reg(CFG_GAP, 16'(gap));
  endtask

  initial begin
    int cmd_pct;
    int sda_pct;
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers but a short settle gap: full-scale direct code,
    // every ACK given at once
    write_reg(CFG_GAP, 16'd4);
    queue_tick(CMD_CODE, 12'hFFF, 12'd0, 1'b0);
    settle_bus(0);

    // Address extremes, zero poll limit fails on the first high sample
    write_all(0, 127, 1, 0, 0);
    queue_tick(CMD_CODE, 12'h000, 12'd0, 1'b1);
    settle_bus(100);
    // Millivolt scaling: full scale, beyond range
    queue_tick(CMD_MVOLT, 12'h000, 12'd3300, 1'b0);
    settle_bus(0);
    queue_tick(CMD_MVOLT, 12'hFFF, 12'd4095, 1'b0);
    settle_bus(0);

    // Zero half period, commands while busy, spare command while idle
    write_all(127, 0, 0, 1, 3);
    queue_tick(CMD_CODE, 12'hA5A, 12'd0, 1'b0);
    queue_tick(CMD_MVOLT, 12'h000, 12'd1234, 1'b0);
    queue_tick(CMD_CODE, 12'h123, 12'd0, 1'b0);
    queue_tick(CMD_SPARE, 12'hFFF, 12'hFFF, 1'b0);
    settle_bus(50);
    queue_tick(CMD_SPARE, 12'h0F0, 12'd100, 1'b1);
    queue_tick(CMD_TICK, 12'hFFF, 12'hFFF, 1'b1);
    settle_bus(0);

    // Longest poll limit with rare high samples, longer settle gap
    write_all(85, 42, 2, 255, 24);
    queue_tick(CMD_CODE, 12'h3C7, 12'd0, 1'b0);
    settle_bus(2);
    // Poll limit running out
    write_reg(CFG_HALF_PER, 16'd1);
    write_reg(CFG_ACK_TMO, 16'd12);
    write_reg(CFG_GAP, 16'd0);
    queue_tick(CMD_MVOLT, 12'h000, 12'd2500, 1'b0);
    settle_bus(100);

    // Random phases: mostly clean ACKs, some storms of commands
    for (int ph = 0; ph < 3; ph++) begin
      write_all($urandom_range(0, 127), $urandom_range(0, 127),
                ($urandom_range(0, 4) != 0) ? $urandom_range(1, 2) : 3,
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(1, 255),
                ($urandom_range(0, 9) < 7) ? $urandom_range(0, 16) : $urandom_range(17, 40));
      pick = $urandom_range(0, 9);
      sda_pct = (pick < 6) ? 0 : (pick < 8) ? 10 : (pick < 9) ? 50 : 100;
      cmd_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(3, 15);
      repeat (30) queue_random(cmd_pct, sda_pct);
      // Pause the stream until every result is back, then carry on
      if (ph == 1) wait_drained();
      repeat (30) queue_random(cmd_pct, sda_pct);
      settle_bus(0);
    end

    repeat (8) @(posedge clk);
    if (expected_pins.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_pins.size()));
    end
    $display("run covered %0d ticks, %0d frames started, %0d ended on ACK timeout",
             ticks_accepted, frames_started, nack_frames);
    $display("%0d settle gaps closed, %0d register writes, %0d results checked, %0d mismatches",
             settle_ends, reg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("i2c_dac_fast_write_master_tb: PASS");
    end else begin
      $display("i2c_dac_fast_write_master_tb: FAIL");
    end
    $finish;
  end

endmodule
